FILE: src/tdpt_pkg.sv
`timescale 1ns / 1ps
// package for the trial division prime tester
// default widths and the status bundle of the remainder unit; no dependencies

package tdpt_pkg;

    localparam int NUM_WIDTH_DEF   = 31;
    localparam int COUNT_WIDTH_DEF = 20;

    // smallest candidate that can be prime
    localparam int MIN_PRIME = 2;

    typedef struct packed {
        logic done;   // one-cycle pulse when a remainder is ready
        logic zero;   // remainder of the last run is zero
    } tdpt_rem_stat_t;

endpackage

FILE: src/tdpt_if.sv
`timescale 1ns / 1ps
// channel interfaces for the trial division prime tester
// valid/ready handshake with candidate and result payloads; no dependencies

interface tdpt_in_if #(
    parameter int NUM_WIDTH = 31
);
    logic                 valid;
    logic                 ready;
    logic [NUM_WIDTH-1:0] candidate;
    logic                 last_in;

    modport source (output valid, output candidate, output last_in, input ready);
    modport sink   (input valid, input candidate, input last_in, output ready);
endinterface

interface tdpt_out_if #(
    parameter int NUM_WIDTH   = 31,
    parameter int COUNT_WIDTH = 20
);
    logic                   valid;
    logic                   ready;
    logic [NUM_WIDTH-1:0]   number;
    logic                   prime_flag;
    logic [COUNT_WIDTH-1:0] prime_count;
    logic                   last_out;

    modport source (output valid, output number, output prime_flag, output prime_count,
                    output last_out, input ready);
    modport sink   (input valid, input number, input prime_flag, input prime_count,
                    input last_out, output ready);
endinterface

FILE: src/tdpt_rem.sv
`timescale 1ns / 1ps
// bit-serial restoring remainder unit, one quotient bit per cycle
// depends on tdpt_pkg for the status bundle

module tdpt_rem #(
    parameter int NUM_WIDTH = 31
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [NUM_WIDTH-1:0]    dividend,
    input  logic [NUM_WIDTH-1:0]    divisor,
    output tdpt_pkg::tdpt_rem_stat_t stat
);
    import tdpt_pkg::*;

    localparam int CNT_W = $clog2(NUM_WIDTH + 1);

    logic [NUM_WIDTH-1:0] shift_reg, shift_next;
    logic [NUM_WIDTH-1:0] rem_reg, rem_next;
    logic [NUM_WIDTH-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [NUM_WIDTH:0]   trial;
    logic [NUM_WIDTH:0]   diff;

    assign trial = {rem_reg, shift_reg[NUM_WIDTH-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        shift_next = shift_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (!busy_reg)
        begin
            if (start)
            begin
                shift_next = dividend;
                rem_next   = '0;
                dvs_next   = divisor;
                cnt_next   = CNT_W'(NUM_WIDTH);
                busy_next  = 1'b1;
            end
        end
        else
        begin
            shift_next = {shift_reg[NUM_WIDTH-2:0], 1'b0};
            // restore when the trial value is below the divisor
            if (trial >= {1'b0, dvs_reg})
                rem_next = diff[NUM_WIDTH-1:0];
            else
                rem_next = trial[NUM_WIDTH-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        dvs_reg   <= dvs_next;
    end

    assign stat.done = done_reg;
    assign stat.zero = (rem_reg == '0);

endmodule

FILE: src/trial_division_prime_test.sv
`timescale 1ns / 1ps
// top level of the trial division prime tester
// depends on tdpt_pkg, tdpt_if and tdpt_rem

// Tests one candidate at a time for primality by trial division and returns one
// result per transaction: the number, a prime flag and the saturating count of
// primes in the current run, which clears after the transaction flagged last.
// The input is not ready while a candidate is under test. Each divisor tried
// first compares the running divisor square with the candidate, then runs the
// bit-serial remainder unit that takes one bit per cycle. A candidate needs at
// most floor(sqrt(n)) - 1 divisors; zero, one, two and three are settled
// without any division. A finished result sits in an output register, so a new
// candidate may start while it waits to be taken.

module trial_division_prime_test #(
    parameter int NUM_WIDTH   = tdpt_pkg::NUM_WIDTH_DEF,
    parameter int COUNT_WIDTH = tdpt_pkg::COUNT_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    tdpt_in_if.sink     req,
    tdpt_out_if.source  rsp
);
    import tdpt_pkg::*;

    localparam int SQ_W = NUM_WIDTH + 2;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_DONE  = 3'd3;

    logic [2:0]             state_reg, state_next;
    logic [NUM_WIDTH-1:0]   n_reg, n_next;
    logic                   last_reg, last_next;
    logic [NUM_WIDTH-1:0]   d_reg, d_next;
    logic [SQ_W-1:0]        sq_reg, sq_next;
    logic                   prime_reg, prime_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic                   ovalid_reg, ovalid_next;
    logic [NUM_WIDTH-1:0]   onum_reg, onum_next;
    logic                   oprime_reg, oprime_next;
    logic [COUNT_WIDTH-1:0] ocount_reg, ocount_next;
    logic                   olast_reg, olast_next;
    logic                   rem_start;
    tdpt_rem_stat_t         rem_stat;
    logic [COUNT_WIDTH-1:0] count_inc;

    tdpt_rem #(
        .NUM_WIDTH (NUM_WIDTH)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (n_reg),
        .divisor  (d_reg),
        .stat     (rem_stat)
    );

    assign req.ready = (state_reg == ST_IDLE);

    // saturating count including the current candidate
    assign count_inc = (prime_reg && (count_reg != '1)) ? count_reg + COUNT_WIDTH'(1)
                                                        : count_reg;

    always_comb
    begin
        state_next  = state_reg;
        n_next      = n_reg;
        last_next   = last_reg;
        d_next      = d_reg;
        sq_next     = sq_reg;
        prime_next  = prime_reg;
        count_next  = count_reg;
        ovalid_next = ovalid_reg;
        onum_next   = onum_reg;
        oprime_next = oprime_reg;
        ocount_next = ocount_reg;
        olast_next  = olast_reg;
        rem_start   = 1'b0;

        if (ovalid_reg && rsp.ready)
            ovalid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    n_next     = req.candidate;
                    last_next  = req.last_in;
                    d_next     = NUM_WIDTH'(MIN_PRIME);
                    sq_next    = SQ_W'(MIN_PRIME * MIN_PRIME);
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (n_reg < NUM_WIDTH'(MIN_PRIME))
                begin
                    prime_next = 1'b0;
                    state_next = ST_DONE;
                end
                else if (sq_reg > {2'b00, n_reg})
                begin
                    prime_next = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    rem_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (rem_stat.done)
                begin
                    if (rem_stat.zero)
                    begin
                        prime_next = 1'b0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        // (d+1)^2 = d^2 + 2d + 1
                        sq_next    = sq_reg + {1'b0, d_reg, 1'b0} + SQ_W'(1);
                        d_next     = d_reg + NUM_WIDTH'(1);
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_DONE:
            begin
                if (!ovalid_reg || rsp.ready)
                begin
                    ovalid_next = 1'b1;
                    onum_next   = n_reg;
                    oprime_next = prime_reg;
                    ocount_next = count_inc;
                    olast_next  = last_reg;
                    count_next  = last_reg ? '0 : count_inc;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        last_reg   <= last_next;
        d_reg      <= d_next;
        sq_reg     <= sq_next;
        prime_reg  <= prime_next;
        onum_reg   <= onum_next;
        oprime_reg <= oprime_next;
        ocount_reg <= ocount_next;
        olast_reg  <= olast_next;
    end

    assign rsp.valid       = ovalid_reg;
    assign rsp.number      = onum_reg;
    assign rsp.prime_flag  = oprime_reg;
    assign rsp.prime_count = ocount_reg;
    assign rsp.last_out    = olast_reg;

endmodule
